/* hdl/crbt_pkg.sv */
// Shared constants and types of the chunked ring buffer tracker.
`timescale 1ns / 1ps
`default_nettype none

package crbt_pkg;

  localparam int DEF_CHUNK_BYTES = 65536;
  localparam int DEF_MAX_CHUNKS  = 64;

  localparam int OP_W        = 2;
  localparam int COUNT_W     = 17;
  localparam int ACTIVE_W    = 7;
  localparam int MARGIN_W    = 17;
  localparam int CHUNK_IDX_W = 6;
  localparam int RD_OFF_W    = 16;
  localparam int SIZE_W      = 17;
  localparam int FILLED_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_QUERY   = 2'd0,
    OP_CONSUME = 2'd1,
    OP_FILL    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CHUNKS = 2'd0,
    REG_CLOSE_MARGIN  = 2'd1
  } reg_idx_e;

endpackage

`default_nettype wire

/* hdl/chunked_ring_buffer_tracker.sv */
// Top level of the chunked ring buffer tracker: descriptor table, pointers and result register.
`timescale 1ns / 1ps
`default_nettype none

// Descriptor manager for a ring of CHUNK_BYTES-sized chunks. Each chunk descriptor
// (filled mark, start offset, end offset) lives in a synchronous RAM, kept in two copies
// so the read chunk and the write chunk are both read every cycle; the read address is
// the next value of each pointer, and the last write is forwarded to the read data.
// An accepted item is executed in its accept cycle against the current descriptors
// (at most one read-modify-write of one descriptor); its result is held pending and
// enters the output register from the updated descriptors once that register is free,
// and a new item may be accepted as the previous one moves into the output register.
// A clear item, a write of active_chunks, and reset each start a clearing pass that
// zeroes every descriptor, one per cycle; items are held off during the pass, while
// configuration writes are taken at any time.
module chunked_ring_buffer_tracker import crbt_pkg::*; #(
  parameter int CHUNK_BYTES = DEF_CHUNK_BYTES,
  parameter int MAX_CHUNKS  = DEF_MAX_CHUNKS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [OP_W-1:0]        operation_i,
  input  wire logic [COUNT_W-1:0]     count_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [CHUNK_IDX_W-1:0]      read_chunk_o,
  output logic [RD_OFF_W-1:0]         read_offset_o,
  output logic [SIZE_W-1:0]           read_size_o,
  output logic [CHUNK_IDX_W-1:0]      write_chunk_o,
  output logic [SIZE_W-1:0]           write_offset_o,
  output logic [SIZE_W-1:0]           write_size_o,
  output logic [FILLED_W-1:0]         filled_chunks_o,
  output logic                        chunk_closed_o,
  output logic                        misuse_o
);

  localparam int PW  = $clog2(MAX_CHUNKS);
  localparam int RSW = $clog2(MAX_CHUNKS + 1);
  localparam int OW  = $clog2(CHUNK_BYTES + 1);
  localparam int CW  = (OW > COUNT_W) ? OW : COUNT_W;
  localparam int EW  = 2 * OW + 1;
  localparam logic [OW-1:0] CB       = OW'(CHUNK_BYTES);
  localparam logic [PW-1:0] LAST_IDX = PW'(MAX_CHUNKS - 1);

  logic [ACTIVE_W-1:0] active_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic                clr_q;
  logic [PW-1:0]       clr_cnt_q;
  logic                clr_start;

  logic                pend_q;
  logic                pend_closed_q;
  logic                pend_misuse_q;
  logic                out_valid_q;
  logic                out_load;
  logic                in_acc;
  logic                cfg_acc;

  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       rd_ram_data, wr_ram_data;
  logic                fwd_we_q;
  logic [PW-1:0]       fwd_addr_q;
  logic [EW-1:0]       fwd_data_q;
  logic [EW-1:0]       er, ew;

  logic                er_full, ew_full;
  logic [OW-1:0]       er_start, er_end, ew_start, ew_end;

  logic [RSW-1:0]      ring;
  logic [31:0]         act32;

  logic [OW-1:0]       avail, new_start;
  logic                c_over;
  logic [CW-1:0]       c_take;
  logic                freed;
  logic [OW-1:0]       freeb, new_end, room;
  logic                f_over;
  logic [CW-1:0]       f_add;
  logic                f_close;
  logic                exec_closed, exec_misuse;

  logic [RSW-1:0]      filled;
  logic [31:0]         rd_ptr32, wr_ptr32, rd_off32, rd_size32, wr_off32, wr_size32;
  logic [31:0]         filled32;

  function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p, input logic [RSW-1:0] rs);
    logic [RSW-1:0] n;
    n = RSW'(p) + RSW'(1);
    return (n >= rs) ? '0 : n[PW-1:0];
  endfunction

  assign act32 = 32'(active_q);
  always_comb begin
    if (active_q == '0) begin
      ring = RSW'(1);
    end else if (act32 > 32'(MAX_CHUNKS)) begin
      ring = RSW'(MAX_CHUNKS);
    end else begin
      ring = act32[RSW-1:0];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign out_load    = pend_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = clr_q | (pend_q & ~out_load);
  assign in_acc      = in_valid_i & ~in_stall_o;

  crbt_ram #(.WIDTH(EW), .DEPTH(MAX_CHUNKS)) u_rd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_d),
    .rdata_o (rd_ram_data)
  );

  crbt_ram #(.WIDTH(EW), .DEPTH(MAX_CHUNKS)) u_wr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (wr_ptr_d),
    .rdata_o (wr_ram_data)
  );

  // forward the last write; treat every descriptor as empty during a clearing pass
  always_comb begin
    er = (fwd_we_q && fwd_addr_q == rd_ptr_q) ? fwd_data_q : rd_ram_data;
    ew = (fwd_we_q && fwd_addr_q == wr_ptr_q) ? fwd_data_q : wr_ram_data;
    if (clr_q) begin
      er = '0;
      ew = '0;
    end
  end

  assign er_full  = er[EW-1];
  assign er_start = er[2*OW-1:OW];
  assign er_end   = er[OW-1:0];
  assign ew_full  = ew[EW-1];
  assign ew_start = ew[2*OW-1:OW];
  assign ew_end   = ew[OW-1:0];

  assign avail     = er_end - er_start;
  assign c_over    = CW'(count_i) > CW'(avail);
  assign c_take    = c_over ? CW'(avail) : CW'(count_i);
  assign new_start = er_start + c_take[OW-1:0];
  assign freed     = (new_start == er_end);

  assign freeb   = CB - ew_end;
  assign f_over  = CW'(count_i) > CW'(freeb);
  assign f_add   = f_over ? CW'(freeb) : CW'(count_i);
  assign new_end = ew_end + f_add[OW-1:0];
  assign room    = CB - new_end;
  assign f_close = (CW'(room) < CW'(margin_q)) || (count_i == '0 && new_end != '0);

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_q;
    ram_wdata   = '0;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    exec_closed = 1'b0;
    exec_misuse = 1'b0;
    clr_start   = 1'b0;
    if (clr_q) begin
      ram_we = 1'b1;
    end else if (in_acc) begin
      unique case (op_e'(operation_i))
        OP_QUERY: begin
        end
        OP_CONSUME: begin
          if (!er_full) begin
            exec_misuse = 1'b1;
          end else begin
            exec_misuse = c_over;
            ram_we      = 1'b1;
            ram_waddr   = rd_ptr_q;
            if (freed) begin
              rd_ptr_d = next_idx(rd_ptr_q, ring);
            end else begin
              ram_wdata = {1'b1, new_start, er_end};
            end
          end
        end
        OP_FILL: begin
          if (ew_full) begin
            exec_misuse = 1'b1;
          end else begin
            exec_misuse = f_over;
            exec_closed = f_close;
            ram_we      = 1'b1;
            ram_waddr   = wr_ptr_q;
            ram_wdata   = {f_close, ew_start, new_end};
            if (f_close) begin
              wr_ptr_d = next_idx(wr_ptr_q, ring);
            end
          end
        end
        OP_CLEAR: begin
          clr_start = 1'b1;
          rd_ptr_d  = '0;
          wr_ptr_d  = '0;
        end
      endcase
    end
    if (cfg_acc && cfg_index_i == REG_ACTIVE_CHUNKS) begin
      clr_start = 1'b1;
      rd_ptr_d  = '0;
      wr_ptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ACTIVE_RESET;
      margin_q    <= MARGIN_RESET;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      fwd_we_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_ACTIVE_CHUNKS: active_q <= cfg_data_i[ACTIVE_W-1:0];
          REG_CLOSE_MARGIN:  margin_q <= cfg_data_i[MARGIN_W-1:0];
          default: begin
          end
        endcase
      end
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fwd_we_q <= ram_we;
      if (clr_start) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end else if (clr_q) begin
        if (clr_cnt_q == LAST_IDX) begin
          clr_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + PW'(1);
        end
      end
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= ram_waddr;
    fwd_data_q <= ram_wdata;
    if (in_acc) begin
      pend_closed_q <= exec_closed;
      pend_misuse_q <= exec_misuse;
    end
  end

  always_comb begin
    if (rd_ptr_q < wr_ptr_q) begin
      filled = RSW'(wr_ptr_q) - RSW'(rd_ptr_q);
    end else if (rd_ptr_q > wr_ptr_q) begin
      filled = ring - RSW'(rd_ptr_q) + RSW'(wr_ptr_q);
    end else begin
      filled = er_full ? ring : '0;
    end
  end

  assign rd_ptr32  = 32'(rd_ptr_q);
  assign wr_ptr32  = 32'(wr_ptr_q);
  assign rd_off32  = er_full ? 32'(er_start) : '0;
  assign rd_size32 = er_full ? 32'(er_end - er_start) : '0;
  assign wr_off32  = ew_full ? '0 : 32'(ew_end);
  assign wr_size32 = ew_full ? '0 : 32'(CB - ew_end);
  assign filled32  = 32'(filled);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_chunk_o    <= rd_ptr32[CHUNK_IDX_W-1:0];
      read_offset_o   <= rd_off32[RD_OFF_W-1:0];
      read_size_o     <= rd_size32[SIZE_W-1:0];
      write_chunk_o   <= wr_ptr32[CHUNK_IDX_W-1:0];
      write_offset_o  <= wr_off32[SIZE_W-1:0];
      write_size_o    <= wr_size32[SIZE_W-1:0];
      filled_chunks_o <= filled32[FILLED_W-1:0];
      chunk_closed_o  <= pend_closed_q;
      misuse_o        <= pend_misuse_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ptr_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RSW'(rd_ptr_q) < ring) && (RSW'(wr_ptr_q) < ring))
    else $error("pointer outside the ring");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_q)
    else $error("accepted item left no pending result");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (clr_q || in_acc))
    else $error("descriptor write outside an item or clearing pass");

  a_pass_end_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> (rd_ptr_q == '0 && wr_ptr_q == '0))
    else $error("clearing pass ended with pointers moved");

endmodule

`default_nettype wire

/* hdl/crbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module crbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
